// File: sv/rtctz_pkg.sv
// Package: shared types, register indexes and calendar helpers for the RTC time-zone block.
package rtctz_pkg;

  // Configuration register indexes
  localparam logic CfgBinaryMode = 1'b0;
  localparam logic CfgZoneOffset = 1'b1;

  // Register reset values
  localparam logic        BinaryModeReset = 1'b0;
  localparam logic [4:0]  ZoneOffsetReset = 5'b11100;  // -4 hours

  // Calendar constants
  localparam logic [11:0] YearBase     = 12'd2000;
  localparam logic [6:0]  HoursPerDay  = 7'd24;
  localparam logic [3:0]  MonthsPerYear = 4'd12;

  // Decoded and range-checked clock snapshot
  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hr;
    logic [4:0]  day;
    logic [3:0]  mon;
    logic [11:0] year;
    logic        leap;
    logic        bad;
  } rtctz_dec_t;

  // Local date and time result
  typedef struct packed {
    logic        field_error;
    logic [11:0] year;
    logic [3:0]  mon;
    logic [4:0]  day;
    logic [4:0]  hr;
    logic [5:0]  min;
    logic [5:0]  sec;
  } rtctz_res_t;

  // Packed BCD byte to binary, nibbles above nine taken as they are
  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

  // Days in a month (1..12); February has 29 in a leap year
  function automatic logic [4:0] days_of(input logic [3:0] mon, input logic leap);
    logic [4:0] d;
    case (mon) inside
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd2:                    d = leap ? 5'd29 : 5'd28;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// File: sv/rtc_datetime_timezone_adjust.sv
// Top level: RTC snapshot to local date and time, with input and result registers.
//
// Input stream (s_axis_*): one raw clock snapshot per transfer, six bytes in tdata.
// Output stream (m_axis_*): one local date/time result per accepted snapshot, in order.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i at the clock edge
//   (0: binary mode, 1: signed hour offset). Write only while the block is empty.
// Path: a snapshot goes into the input register, then through decode, offset and rollover
//   logic into the result register.
// Throughput: one snapshot per cycle while m_axis_tready is high; two registers, no loop.
// Stall: when the receiver holds m_axis_tready low, the result register keeps its
//   transfer, the input register still takes one more snapshot, and s_axis_tready
//   then drops until the result is taken.
// Reset (rst_ni low, asynchronous): both pipeline stages empty, binary mode off,
//   offset -4 hours.
// A snapshot with any field out of range gives field_error set and all other fields zero.
module rtc_datetime_timezone_adjust (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] raw_seconds, [15:8] raw_minutes, [23:16] raw_hours,
  // [31:24] raw_day, [39:32] raw_month, [47:40] raw_year
  input  logic [47:0] s_axis_tdata,
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] local_seconds, [11:6] local_minutes, [16:12] local_hours,
  // [21:17] local_day, [25:22] local_month, [37:26] local_year,
  // [38] field_error, [39] zero
  output logic [39:0] m_axis_tdata,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [4:0]  cfg_wdata_i
);
  import rtctz_pkg::*;

  logic        binary_mode_q;
  logic [4:0]  zone_offset_q;
  logic        in_valid_q, in_valid_d;
  logic [47:0] in_data_q;
  logic        out_valid_q, out_valid_d;
  rtctz_res_t  out_res_q;
  logic        out_free, in_free;
  rtctz_dec_t  dec;
  rtctz_res_t  res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binary_mode_q <= BinaryModeReset;
      zone_offset_q <= ZoneOffsetReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgBinaryMode: binary_mode_q <= cfg_wdata_i[0];
        CfgZoneOffset: zone_offset_q <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // Pipeline flow control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_free       = !in_valid_q || out_free;
  assign s_axis_tready = in_free;
  assign in_valid_d    = in_free ? s_axis_tvalid : in_valid_q;
  assign out_valid_d   = out_free ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && in_free) begin
      in_data_q <= s_axis_tdata;
    end
    if (in_valid_q && out_free) begin
      out_res_q <= res;
    end
  end

  // Conversion and range check
  rtctz_decode u_decode (
    .raw_seconds_i (in_data_q[7:0]),
    .raw_minutes_i (in_data_q[15:8]),
    .raw_hours_i   (in_data_q[23:16]),
    .raw_day_i     (in_data_q[31:24]),
    .raw_month_i   (in_data_q[39:32]),
    .raw_year_i    (in_data_q[47:40]),
    .binary_mode_i (binary_mode_q),
    .dec_o         (dec)
  );

  // Offset and date rollover
  rtctz_adjust u_adjust (
    .dec_i         (dec),
    .zone_offset_i (signed'(zone_offset_q)),
    .res_o         (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q};

`ifndef ASSERT_OFF
  // An error result carries no date or time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res_q.field_error) |-> (m_axis_tdata[37:0] == 38'd0))
    else $error("error result with non-zero fields");

  // A good result has calendar-range hours, day and month
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_res_q.field_error) |->
      (out_res_q.hr < 5'd24 && out_res_q.day != 5'd0 &&
       out_res_q.mon != 4'd0 && out_res_q.mon <= MonthsPerYear))
    else $error("result out of calendar range");

  // An accepted snapshot always lands in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> in_valid_q)
    else $error("accepted snapshot lost");

  // A held snapshot moves to the result register when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_free) |=> m_axis_tvalid)
    else $error("snapshot not forwarded to result register");
`endif

endmodule

// File: sv/rtctz_decode.sv
// Module: converts one raw clock snapshot to binary and checks each field's calendar range.
module rtctz_decode (
  input  logic [7:0]          raw_seconds_i,
  input  logic [7:0]          raw_minutes_i,
  input  logic [7:0]          raw_hours_i,
  input  logic [7:0]          raw_day_i,
  input  logic [7:0]          raw_month_i,
  input  logic [7:0]          raw_year_i,
  input  logic                binary_mode_i,
  output rtctz_pkg::rtctz_dec_t dec_o
);
  import rtctz_pkg::*;

  logic [7:0] sec, min, hr, day, mon, ylo;
  logic       leap;
  logic       bad_basic;
  logic [4:0] mdays;

  // BCD or binary interpretation of every byte
  assign sec = binary_mode_i ? raw_seconds_i : from_bcd(raw_seconds_i);
  assign min = binary_mode_i ? raw_minutes_i : from_bcd(raw_minutes_i);
  assign hr  = binary_mode_i ? raw_hours_i   : from_bcd(raw_hours_i);
  assign day = binary_mode_i ? raw_day_i     : from_bcd(raw_day_i);
  assign mon = binary_mode_i ? raw_month_i   : from_bcd(raw_month_i);
  assign ylo = binary_mode_i ? raw_year_i    : from_bcd(raw_year_i);

  // 2000 is a multiple of four, so the low year alone decides leap years
  assign leap = (ylo[1:0] == 2'b00);

  // Range checks; the day check only matters once the month is known good
  assign bad_basic = (sec > 8'd59) || (min > 8'd59) || (hr > 8'd23) ||
                     (mon < 8'd1) || (mon > {4'd0, MonthsPerYear}) || (ylo > 8'd99);
  assign mdays = days_of(mon[3:0], leap);

  always_comb begin
    dec_o.sec  = sec[5:0];
    dec_o.min  = min[5:0];
    dec_o.hr   = hr[4:0];
    dec_o.day  = day[4:0];
    dec_o.mon  = mon[3:0];
    dec_o.year = YearBase + {5'd0, ylo[6:0]};
    dec_o.leap = leap;
    dec_o.bad  = bad_basic || (day < 8'd1) || (day > {3'd0, mdays});
  end

endmodule

// File: sv/rtctz_adjust.sv
// Module: applies the hour offset, rolls the date one day forward or back, flags bad snapshots.
module rtctz_adjust (
  input  rtctz_pkg::rtctz_dec_t dec_i,
  input  logic signed [4:0]     zone_offset_i,
  output rtctz_pkg::rtctz_res_t res_o
);
  import rtctz_pkg::*;

  logic signed [6:0] h_sum;
  logic              under, over;
  logic [6:0]        h_wrap;
  logic [4:0]        mdays;
  logic [4:0]        prev_mdays;
  logic [3:0]        prev_mon;
  logic [11:0]       prev_year;

  // Hour sum ranges -16..38, so one wrap of a day is enough
  assign h_sum = signed'({2'b00, dec_i.hr}) + 7'(zone_offset_i);
  assign under = h_sum[6];
  assign over  = !under && (h_sum >= signed'(HoursPerDay));
  assign h_wrap = under ? 7'(h_sum) + HoursPerDay :
                  over  ? 7'(h_sum) - HoursPerDay : 7'(h_sum);

  // Month lengths for this month and the one before
  assign mdays      = days_of(dec_i.mon, dec_i.leap);
  assign prev_mon   = (dec_i.mon == 4'd1) ? MonthsPerYear : dec_i.mon - 4'd1;
  assign prev_year  = (dec_i.mon == 4'd1) ? dec_i.year - 12'd1 : dec_i.year;
  assign prev_mdays = days_of(prev_mon, dec_i.leap);

  // Date rollover and error zeroing
  always_comb begin
    res_o = '0;
    res_o.sec  = dec_i.sec;
    res_o.min  = dec_i.min;
    res_o.hr   = h_wrap[4:0];
    res_o.day  = dec_i.day;
    res_o.mon  = dec_i.mon;
    res_o.year = dec_i.year;
    if (under) begin
      if (dec_i.day > 5'd1) begin
        res_o.day = dec_i.day - 5'd1;
      end else begin
        res_o.day  = prev_mdays;
        res_o.mon  = prev_mon;
        res_o.year = prev_year;
      end
    end else if (over) begin
      if (dec_i.day < mdays) begin
        res_o.day = dec_i.day + 5'd1;
      end else begin
        res_o.day = 5'd1;
        if (dec_i.mon < MonthsPerYear) begin
          res_o.mon = dec_i.mon + 4'd1;
        end else begin
          res_o.mon  = 4'd1;
          res_o.year = dec_i.year + 12'd1;
        end
      end
    end
    if (dec_i.bad) begin
      res_o = '0;
      res_o.field_error = 1'b1;
    end
  end

endmodule

// File: sim/rtctz_local_time_checker.sv
// Checker: predicts local date and time for each accepted snapshot and compares results.
module rtctz_local_time_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Snapshot channel as seen at the block's input
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  // [7:0] raw_seconds, [15:8] raw_minutes, [23:16] raw_hours,
  // [31:24] raw_day, [39:32] raw_month, [47:40] raw_year
  input  logic [47:0] in_data_i,
  // Result channel as seen at the block's output
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  // [5:0] local_seconds, [11:6] local_minutes, [16:12] local_hours,
  // [21:17] local_day, [25:22] local_month, [37:26] local_year,
  // [38] field_error, [39] zero
  input  logic [39:0] out_data_i,
  // Register writes
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [4:0]  cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rtctz_pkg::*;

  localparam int MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Shadow copy of the two registers
  logic       binary_mode;
  logic [4:0] zone_offset;

  // Local times still owed by the block, oldest first
  rtctz_res_t local_time_q [$];

  // Month length, every fourth year a leap year
  function automatic int unsigned month_len_days(input int unsigned mon,
                                                 input int unsigned year);
    if (mon == 2 && year % 4 == 0) return 29;
    return MonthDays[mon - 1];
  endfunction

  // Decode, range check, add the zone offset and roll the date by a day if needed
  function automatic rtctz_res_t local_time_of(input logic [47:0] raw);
    rtctz_res_t  res;
    int unsigned f [6];
    int unsigned day, mon, year;
    int          hr, off;
    logic [7:0]  b;
    logic        bad;
    res = '0;
    for (int i = 0; i < 6; i++) begin
      b = raw[8*i +: 8];
      // nibbles above nine are weighted as they are
      f[i] = binary_mode ? int'(b) : b[7:4] * 10 + b[3:0];
    end
    day  = f[3];
    mon  = f[4];
    year = 2000 + f[5];
    bad  = f[0] > 59 || f[1] > 59 || f[2] > 23 || mon < 1 || mon > 12 || f[5] > 99;
    if (!bad && (day < 1 || day > month_len_days(mon, year))) bad = 1'b1;
    if (bad) begin
      res.field_error = 1'b1;
      return res;
    end

    off = $signed(zone_offset);
    hr  = $signed(f[2]) + off;
    if (hr < 0) begin
      // back one day
      hr += 24;
      if (day > 1) begin
        day--;
      end else begin
        if (mon > 1) begin
          mon--;
        end else begin
          mon = 12;
          year--;
        end
        day = month_len_days(mon, year);
      end
    end else if (hr >= 24) begin
      // forward one day
      hr -= 24;
      if (day < month_len_days(mon, year)) begin
        day++;
      end else begin
        day = 1;
        if (mon < 12) begin
          mon++;
        end else begin
          mon = 1;
          year++;
        end
      end
    end

    res.sec  = 6'(f[0]);
    res.min  = 6'(f[1]);
    res.hr   = 5'(hr);
    res.day  = 5'(day);
    res.mon  = 4'(mon);
    res.year = 12'(year);
    return res;
  endfunction

  // Track register writes, queue predictions, check results in order
  always @(posedge clk_i or negedge rst_ni) begin
    rtctz_res_t want, got;
    if (!rst_ni) begin
      binary_mode = BinaryModeReset;
      zone_offset = ZoneOffsetReset;
      local_time_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CfgBinaryMode) binary_mode = cfg_wdata_i[0];
        else                             zone_offset = cfg_wdata_i;
      end

      if (in_valid_i && in_ready_i) local_time_q.push_back(local_time_of(in_data_i));

      if (out_valid_i && out_ready_i) begin
        got = rtctz_res_t'(out_data_i[38:0]);
        if (local_time_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result transfer with none outstanding: %h", $time, out_data_i);
        end else begin
          want = local_time_q.pop_front();
          if (got !== want || out_data_i[39] !== 1'b0) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"%0t: mismatch: want err=%0d %0d-%0d-%0d %0d:%0d:%0d, ",
                        "got err=%0d %0d-%0d-%0d %0d:%0d:%0d pad=%0d"}, $time,
                       want.field_error, want.year, want.mon, want.day,
                       want.hr, want.min, want.sec,
                       got.field_error, got.year, got.mon, got.day,
                       got.hr, got.min, got.sec, out_data_i[39]);
          end
        end
      end
    end
    pending_o = local_time_q.size();
  end

endmodule

// File: sim/tb_rtc_datetime_timezone_adjust.sv
// Testbench top: clock, reset, snapshot stimulus, result back-pressure and verdict.
module tb_rtc_datetime_timezone_adjust;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles = 250;
  localparam int StallLimit = 2000;
  localparam int PhaseItems = 148;
  localparam int MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  // Register settings of the random phases
  localparam logic PhaseBinary [9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam int   PhaseOffset [6] = '{-12, 14, 0, -16, 15, -4};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_addr_i    = 1'b0;
  logic [4:0]  cfg_wdata_i   = '0;

  int fail_count;
  int pending;

  // Encoding used for generated snapshots; follows the binary_mode register
  logic bin_mode = 1'b0;
  int   send_gap_pct;
  int   recv_idle_pct;
  int   hold_asked = 0;
  int   hold_seen  = 0;
  int   hold_left  = 0;
  int   stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  rtc_datetime_timezone_adjust u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  rtctz_local_time_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Result side: random stalls, plus a long hold-off when asked for
  always @(negedge clk_i) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned days_in(input int unsigned mon, input int unsigned ylo);
    if (mon == 2 && ylo % 4 == 0) return 29;
    return MonthDays[mon - 1];
  endfunction

  // One clock byte in the current encoding; BCD values above 99 get a high nibble over 9
  function automatic logic [7:0] enc(input int unsigned v);
    if (bin_mode) return 8'(v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic logic [47:0] clock_bytes(input int unsigned sec, mi, hr, day, mon, ylo);
    return {enc(ylo), enc(mon), enc(day), enc(hr), enc(mi), enc(sec)};
  endfunction

  // Mostly valid snapshots biased towards day, month and year edges; some noise,
  // some with a single field out of range
  function automatic logic [47:0] random_snapshot();
    int unsigned f [6];
    int unsigned md, pick, ceiling;
    logic [47:0] raw;
    pick = $urandom_range(99);
    if (pick < 12) return 48'({$urandom(), $urandom()});

    f[5] = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 99 : 0) : $urandom_range(99);
    case ($urandom_range(5))
      0:       f[4] = 1;
      1:       f[4] = 2;
      2:       f[4] = 12;
      default: f[4] = $urandom_range(1, 12);
    endcase
    md = days_in(f[4], f[5]);
    case ($urandom_range(4))
      0:       f[3] = 1;
      1:       f[3] = md;
      default: f[3] = $urandom_range(1, md);
    endcase
    if ($urandom_range(1))
      f[2] = $urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(20, 23);
    else
      f[2] = $urandom_range(23);
    f[1] = ($urandom_range(9) == 0) ? 59 : $urandom_range(59);
    f[0] = ($urandom_range(9) == 0) ? 59 : $urandom_range(59);

    ceiling = bin_mode ? 255 : 159;
    if (pick < 26) begin
      case ($urandom_range(5))
        0:       f[0] = $urandom_range(60, ceiling);
        1:       f[1] = $urandom_range(60, ceiling);
        2:       f[2] = $urandom_range(24, ceiling);
        3:       f[3] = $urandom_range(1) ? 0 : $urandom_range(md + 1, md + 8);
        4:       f[4] = $urandom_range(1) ? 0 : $urandom_range(13, ceiling);
        default: f[5] = $urandom_range(100, ceiling);
      endcase
    end

    for (int i = 0; i < 6; i++) begin
      raw[8*i +: 8] = enc(f[i]);
      // same value with a borrowed ten in the low nibble
      if (!bin_mode && f[i] >= 10 && f[i] % 10 <= 5 && $urandom_range(9) == 0)
        raw[8*i +: 8] = {4'(f[i] / 10 - 1), 4'(f[i] % 10 + 10)};
    end
    return raw;
  endfunction

  // Offer one snapshot, with a random gap first; returns at the falling edge after the transfer
  task automatic send_snapshot(input logic [47:0] snap);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= snap;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic addr, input logic [4:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold the input back until every outstanding result has been taken
  task automatic settle();
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  initial begin
    send_gap_pct  = 10;
    recv_idle_pct = 83;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers at reset values: BCD, minus four hours
    send_snapshot(clock_bytes(0, 0, 0, 1, 1, 0));        // back into 1999
    send_snapshot(clock_bytes(59, 59, 23, 31, 12, 99));
    send_snapshot(clock_bytes(30, 15, 2, 1, 3, 24));     // back to leap day
    send_snapshot(clock_bytes(0, 0, 3, 1, 3, 23));       // back to 28 Feb
    send_snapshot(48'h1F_0A_0F_0C_2F_1A);                // nibbles above nine, still valid
    send_snapshot(48'h0);
    send_snapshot(48'hFFFF_FFFF_FFFF);
    send_snapshot(clock_bytes(60, 0, 12, 15, 6, 10));
    send_snapshot(clock_bytes(0, 60, 12, 15, 6, 10));
    send_snapshot(clock_bytes(0, 0, 24, 15, 6, 10));
    send_snapshot(clock_bytes(0, 0, 12, 0, 6, 10));
    send_snapshot(clock_bytes(0, 0, 12, 29, 2, 23));     // no leap day
    send_snapshot(clock_bytes(0, 0, 12, 29, 2, 24));
    send_snapshot(clock_bytes(0, 0, 12, 31, 4, 10));
    send_snapshot(clock_bytes(0, 0, 12, 1, 13, 10));
    send_snapshot(clock_bytes(0, 0, 12, 1, 6, 100));
    s_axis_tvalid <= 1'b0;

    // Largest positive offset: forward rollovers
    settle();
    write_reg(rtctz_pkg::CfgZoneOffset, 5'd15);
    send_snapshot(clock_bytes(5, 6, 23, 31, 12, 99));    // into 2100
    send_snapshot(clock_bytes(0, 0, 9, 28, 2, 24));      // on to leap day
    send_snapshot(clock_bytes(0, 0, 20, 30, 6, 10));
    s_axis_tvalid <= 1'b0;

    // Binary bytes, most negative offset
    settle();
    bin_mode = 1'b1;
    write_reg(rtctz_pkg::CfgBinaryMode, {4'($urandom()), 1'b1});
    write_reg(rtctz_pkg::CfgZoneOffset, 5'b10000);
    send_snapshot(48'hFFFF_FFFF_FFFF);
    send_snapshot(clock_bytes(59, 59, 23, 31, 12, 99));
    send_snapshot(clock_bytes(0, 0, 15, 1, 1, 0));
    send_snapshot(clock_bytes(0, 0, 0, 1, 6, 100));
    send_snapshot(clock_bytes(0, 0, 16, 1, 1, 0));
    s_axis_tvalid <= 1'b0;

    // Random phases over several register settings and stall patterns
    for (int p = 0; p < 9; p++) begin
      settle();
      bin_mode = PhaseBinary[p];
      write_reg(rtctz_pkg::CfgBinaryMode, {4'($urandom()), PhaseBinary[p]});
      if (p < 6) write_reg(rtctz_pkg::CfgZoneOffset, 5'(PhaseOffset[p]));
      else       write_reg(rtctz_pkg::CfgZoneOffset, 5'($urandom_range(31)));
      if (p < 3) begin
        send_gap_pct  = 10;
        recv_idle_pct = 83;
      end else if (p < 6) begin
        send_gap_pct  = 83;
        recv_idle_pct = 10;
      end else begin
        send_gap_pct  = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        // long hold-off on results while snapshots keep coming
        if (p == 6 && n == 40) hold_asked++;
        send_snapshot(random_snapshot());
      end
      s_axis_tvalid <= 1'b0;
    end

    settle();
    repeat (4) @(negedge clk_i);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
